// ----- rtl/lpt_pkg.sv -----
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants of the latency percentile tracker.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int unsigned LptRingDepth = 64;
  localparam int unsigned LptDatW      = 32;
  localparam int unsigned LptSumW      = 64;

  // floor(x / 100) as (x * LptRecipMul) >> LptRecipShift, exact for x < 2**LptRankW
  localparam int unsigned LptRankW     = 17;
  localparam int unsigned LptRecipW    = 20;
  localparam int unsigned LptRecipShift = 26;
  localparam logic [LptRecipW-1:0] LptRecipMul = 20'd671089;
  localparam logic [6:0] LptP99Num = 7'd99;

  typedef enum logic [0:0] {
    MODE_RECORD = 1'b0,
    MODE_QUERY  = 1'b1
  } lpt_mode_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } lpt_state_e;

  typedef enum logic [2:0] {
    SL_IDLE,
    SL_MUL,
    SL_RANK,
    SL_CAND,
    SL_LATCH,
    SL_SCAN,
    SL_CHECK,
    SL_DONE
  } lpt_sel_state_e;

  typedef struct packed {
    logic               done;
    logic [LptDatW-1:0] median;
    logic [LptDatW-1:0] p99;
  } lpt_sel_stat_t;

endpackage

// ----- rtl/lpt_div.sv -----
// ----------------------------------------------------------------------------
// lpt_div
// Restoring divider, one quotient bit per cycle; keeps the low quotient word.
// ----------------------------------------------------------------------------
module lpt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lpt_pkg::LptSumW-1:0]   dividend_i,
  input  logic [lpt_pkg::LptDatW-1:0]   divisor_i,
  output logic                          done_o,
  output logic [lpt_pkg::LptDatW-1:0]   quot_o
);
  import lpt_pkg::*;

  localparam int unsigned CntW = $clog2(LptSumW + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [LptDatW-1:0] rem_q, rem_d;
  logic [LptSumW-1:0] dvd_q, dvd_d;
  logic [LptDatW-1:0] dsr_q, dsr_d;
  logic [LptDatW-1:0] quo_q, quo_d;
  logic [LptDatW:0]   shifted;
  logic               take;

  always_comb begin
    shifted = {rem_q, dvd_q[LptSumW-1]};
    take    = shifted >= {1'b0, dsr_q};
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = done_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    if (start_i) begin
      cnt_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      quo_d  = '0;
    end else if (run_q) begin
      rem_d = take ? LptDatW'(shifted - {1'b0, dsr_q}) : shifted[LptDatW-1:0];
      dvd_d = {dvd_q[LptSumW-2:0], 1'b0};
      quo_d = {quo_q[LptDatW-2:0], take};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(LptSumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/lpt_select.sv -----
// ----------------------------------------------------------------------------
// lpt_select
// Sample ring memory and rank selection by counting over the stored samples.
// ----------------------------------------------------------------------------
module lpt_select #(
  parameter int unsigned RING_DEPTH = lpt_pkg::LptRingDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [$clog2(RING_DEPTH)-1:0]       wr_addr_i,
  input  logic [lpt_pkg::LptDatW-1:0]         wr_data_i,
  input  logic                                start_i,
  input  logic [$clog2(RING_DEPTH+1)-1:0]     fill_i,
  output lpt_pkg::lpt_sel_stat_t              stat_o
);
  import lpt_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned PW = LptRankW + LptRecipW;

  lpt_sel_state_e state_q, state_d;

  logic [LptDatW-1:0] mem_q [RING_DEPTH];
  logic [LptDatW-1:0] rdata_q;
  logic [AW-1:0]      rd_addr;

  logic [CW-1:0]       n_q;
  logic [LptRankW-1:0] x_q;
  logic [PW-1:0]       prod_q;
  logic [CW-1:0]       kmed_q, k99_q;
  logic [AW-1:0]       c_q, j_q;
  logic [LptDatW-1:0]  cand_q, med_q, p99_q;
  logic [CW-1:0]       lt_q, le_q;
  logic                j_last, c_last;

  assign j_last = (CW'(j_q) + 1'b1) == n_q;
  assign c_last = (CW'(c_q) + 1'b1) == n_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SL_IDLE, SL_DONE: if (start_i) state_d = SL_MUL;
      SL_MUL:   state_d = SL_RANK;
      SL_RANK:  state_d = SL_CAND;
      SL_CAND:  state_d = SL_LATCH;
      SL_LATCH: state_d = SL_SCAN;
      SL_SCAN:  if (j_last) state_d = SL_CHECK;
      SL_CHECK: state_d = c_last ? SL_DONE : SL_CAND;
      default:  state_d = SL_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = '0;
    case (state_q)
      SL_CAND: rd_addr = c_q;
      SL_SCAN: rd_addr = AW'(j_q + 1'b1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SL_IDLE, SL_DONE: begin
        if (start_i) begin
          n_q <= fill_i;
          x_q <= LptRankW'(fill_i) * LptRankW'(LptP99Num);
          c_q <= '0;
        end
      end
      SL_MUL: prod_q <= PW'(x_q) * PW'(LptRecipMul);
      SL_RANK: begin
        k99_q  <= prod_q[LptRecipShift +: CW];
        kmed_q <= n_q >> 1;
      end
      SL_LATCH: begin
        cand_q <= rdata_q;
        j_q    <= '0;
        lt_q   <= '0;
        le_q   <= '0;
      end
      SL_SCAN: begin
        if (rdata_q < cand_q)  lt_q <= lt_q + 1'b1;
        if (rdata_q <= cand_q) le_q <= le_q + 1'b1;
        j_q <= AW'(j_q + 1'b1);
      end
      SL_CHECK: begin
        if (lt_q <= kmed_q && kmed_q < le_q) med_q <= cand_q;
        if (lt_q <= k99_q && k99_q < le_q)   p99_q <= cand_q;
        c_q <= AW'(c_q + 1'b1);
      end
      default: ;
    endcase
  end

  assign stat_o.done   = state_q == SL_DONE;
  assign stat_o.median = med_q;
  assign stat_o.p99    = p99_q;

endmodule

// ----- rtl/latency_percentile_tracker_top.sv -----
// ----------------------------------------------------------------------------
// latency_percentile_tracker_top
// Latency sample ring with running min, max, mean, count and rank queries.
// ----------------------------------------------------------------------------
// A record is taken without a busy phase; busy stays low and no result follows.
// An empty query gives its result strobe on the next cycle.
// Other queries strobe once the rank scan and the mean divider are both done;
// the rank scan reads the ring through one memory port, all n stored samples
// for each of the n candidates, and the divider walks all 64 dividend bits.
// The result is shown for one cycle; the receiver cannot stall.
// Reset clears all statistics; ring contents are not cleared.
// ----------------------------------------------------------------------------
module latency_percentile_tracker_top #(
  parameter int unsigned RING_DEPTH = lpt_pkg::LptRingDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [lpt_pkg::LptDatW-1:0] latency_i,
  output logic                        valid_o,
  output logic                        empty_res_o,
  output logic [lpt_pkg::LptDatW-1:0] min_latency_o,
  output logic [lpt_pkg::LptDatW-1:0] max_latency_o,
  output logic [lpt_pkg::LptDatW-1:0] mean_latency_o,
  output logic [lpt_pkg::LptDatW-1:0] samples_seen_o,
  output logic [lpt_pkg::LptDatW-1:0] median_latency_o,
  output logic [lpt_pkg::LptDatW-1:0] p99_latency_o
);
  import lpt_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);

  lpt_state_e state_q, state_d;

  logic [AW-1:0]      wp_q;
  logic [CW-1:0]      fill_q;
  logic [LptSumW-1:0] sum_q;
  logic [LptDatW-1:0] cnt_q, min_q, max_q;

  logic               valid_q, empty_q;
  logic [LptDatW-1:0] r_min_q, r_max_q, r_mean_q, r_cnt_q, r_med_q, r_p99_q;

  logic          accept, rec, qry, qry_go, finish;
  logic          div_done;
  logic [LptDatW-1:0] quot;
  lpt_sel_stat_t sel_stat;

  assign accept = start && !busy;
  assign rec    = accept && (mode_i == MODE_RECORD);
  assign qry    = accept && (mode_i == MODE_QUERY);
  assign qry_go = qry && (fill_q != '0);
  assign finish = (state_q == ST_RUN) && sel_stat.done && div_done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (qry_go) state_d = ST_RUN;
      ST_RUN:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = state_q != ST_IDLE;
  end

  lpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (qry_go),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  lpt_select #(
    .RING_DEPTH (RING_DEPTH)
  ) u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rec),
    .wr_addr_i (wp_q),
    .wr_data_i (latency_i),
    .start_i   (qry_go),
    .fill_i    (fill_q),
    .stat_o    (sel_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (qry && !qry_go) || finish;
      if (rec) begin
        wp_q  <= (wp_q == AW'(RING_DEPTH - 1)) ? '0 : AW'(wp_q + 1'b1);
        if (fill_q != CW'(RING_DEPTH)) fill_q <= fill_q + 1'b1;
        sum_q <= sum_q + LptSumW'(latency_i);
        if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
        if (min_q == '0 || latency_i < min_q) min_q <= latency_i;
        if (latency_i > max_q) max_q <= latency_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (qry && !qry_go) begin
      empty_q  <= 1'b1;
      r_min_q  <= '0;
      r_max_q  <= '0;
      r_mean_q <= '0;
      r_cnt_q  <= '0;
      r_med_q  <= '0;
      r_p99_q  <= '0;
    end else if (finish) begin
      empty_q  <= 1'b0;
      r_min_q  <= min_q;
      r_max_q  <= max_q;
      r_mean_q <= quot;
      r_cnt_q  <= cnt_q;
      r_med_q  <= sel_stat.median;
      r_p99_q  <= sel_stat.p99;
    end
  end

  assign valid_o          = valid_q;
  assign empty_res_o      = empty_q;
  assign min_latency_o    = r_min_q;
  assign max_latency_o    = r_max_q;
  assign mean_latency_o   = r_mean_q;
  assign samples_seen_o   = r_cnt_q;
  assign median_latency_o = r_med_q;
  assign p99_latency_o    = r_p99_q;

  a_record_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec |=> !valid_o)
    else $error("record transfer produced a result");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(RING_DEPTH))
    else $error("fill level beyond ring depth");

  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !empty_res_o |-> median_latency_o <= p99_latency_o &&
      p99_latency_o <= max_latency_o)
    else $error("rank results out of order");

endmodule
